[src/circle_segment_contact_macros.svh]
// Assertion macros for the circle/segment contact block.
`ifndef CIRCLE_SEGMENT_CONTACT_MACROS_SVH
`define CIRCLE_SEGMENT_CONTACT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define CSC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define CSC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/csc_pkg.sv]
package csc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = 32;
   localparam int RAD_W     = 31;
   localparam int NORM_W    = FRAC_BITS + 2;

   localparam int DIFF_W  = COORD_W + 1;         // endpoint/center differences
   localparam int PROD_W  = 2 * DIFF_W;          // signed square / cross products
   localparam int LEN_W   = 2 * COORD_W + 2;     // squared length, squared distance
   localparam int DOT_W   = 2 * COORD_W + 3;     // signed dot product
   localparam int SPLIT_W = DIFF_W;              // low slice of dot for partial products

   // projection divider
   localparam int PQ_BITS = DIFF_W;
   localparam int PN_W    = LEN_W + PQ_BITS - 1;
   localparam int PC_W    = LEN_W + PQ_BITS;

   // square root
   localparam int SQ_STEPS = 32;
   localparam int SQ_W     = 64;
   localparam int ROOT_W   = 32;

   // normal divider
   localparam int NQ_BITS = FRAC_BITS + 1;
   localparam int NN_W    = RAD_W + FRAC_BITS;
   localparam int ND_W    = ROOT_W;
   localparam int NC_W    = ND_W + NQ_BITS;

   localparam int FRONT_STAGES = 5;
   localparam int LATENCY = FRONT_STAGES + PQ_BITS + 3 + SQ_STEPS + 1 + NQ_BITS + 1;

   localparam logic [NQ_BITS-1:0] NORM_ONE = NQ_BITS'(1) << FRAC_BITS;

   typedef enum logic [1:0] {
      KSEL_START,
      KSEL_END,
      KSEL_DIV
   } ksel_type;

   typedef struct packed {
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic [RAD_W-1:0]   r;
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] sy;
      logic [COORD_W-1:0] bx;
      logic [COORD_W-1:0] by;
      logic               neg_x;
      logic               neg_y;
      ksel_type           sel;
   } proj_side_type;

   typedef struct packed {
      logic               touch;
      logic               on_seg;
      logic [COORD_W-1:0] kx;
      logic [COORD_W-1:0] ky;
      logic [RAD_W-1:0]   r;
      logic [RAD_W-1:0]   mx;
      logic [RAD_W-1:0]   my;
      logic               sgx;
      logic               sgy;
   } sqrt_side_type;

   typedef struct packed {
      logic               touch;
      logic               on_seg;
      logic [COORD_W-1:0] kx;
      logic [COORD_W-1:0] ky;
      logic [RAD_W-1:0]   pen;
      logic               sgx;
      logic               sgy;
   } norm_side_type;

endpackage

[src/csc_front.sv]
module csc_front import csc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [COORD_W-1:0]   center_x,
   input  logic [COORD_W-1:0]   center_y,
   input  logic [RAD_W-1:0]     radius,
   input  logic [COORD_W-1:0]   start_x,
   input  logic [COORD_W-1:0]   start_y,
   input  logic [COORD_W-1:0]   end_x,
   input  logic [COORD_W-1:0]   end_y,
   output logic                 out_valid,
   output logic [PN_W-1:0]      num_x,
   output logic [PN_W-1:0]      num_y,
   output logic [LEN_W-1:0]     len,
   output proj_side_type        out_side
);

   // stage 1: differences
   logic signed [DIFF_W-1:0] ex_in, ey_in, px_in, py_in;
   logic signed [DIFF_W-1:0] ex_ff, ey_ff, px_ff, py_ff;
   logic [DIFF_W-1:0]        mex_in, mey_in, mex1_ff, mey1_ff;
   proj_side_type            side_in, side1_ff;
   logic                     vld1_ff;

   // stage 2: products
   logic signed [PROD_W-1:0] exx_in, eyy_in, pxe_in, pye_in;
   logic signed [PROD_W-1:0] exx_ff, eyy_ff, pxe_ff, pye_ff;
   logic [DIFF_W-1:0]        mex2_ff, mey2_ff;
   proj_side_type            side2_ff;
   logic                     vld2_ff;

   // stage 3: length and dot
   logic [LEN_W-1:0]         len3_in, len3_ff;
   logic signed [DOT_W-1:0]  dot_in, dot_ff;
   logic [DIFF_W-1:0]        mex3_ff, mey3_ff;
   proj_side_type            side3_ff;
   logic                     vld3_ff;

   // stage 4: clamp decision, partial products
   logic                     dot_pos;
   logic [2*SPLIT_W-1:0]     plx_in, ply_in, plx_ff, ply_ff;
   logic [2*SPLIT_W-2:0]     phx_in, phy_in, phx_ff, phy_ff;
   logic [LEN_W-1:0]         len4_ff;
   proj_side_type            side4_in, side4_ff;
   logic                     vld4_ff;

   // stage 5: numerators
   logic [PN_W-1:0]          nx_in, ny_in, nx_ff, ny_ff;
   logic [LEN_W-1:0]         len5_ff;
   proj_side_type            side5_ff;
   logic                     vld5_ff;

   always_comb begin
      ex_in = $signed({end_x[COORD_W-1], end_x}) - $signed({start_x[COORD_W-1], start_x});
      ey_in = $signed({end_y[COORD_W-1], end_y}) - $signed({start_y[COORD_W-1], start_y});
      px_in = $signed({center_x[COORD_W-1], center_x})
            - $signed({start_x[COORD_W-1], start_x});
      py_in = $signed({center_y[COORD_W-1], center_y})
            - $signed({start_y[COORD_W-1], start_y});
      mex_in = ex_in[DIFF_W-1] ? DIFF_W'(-ex_in) : DIFF_W'(ex_in);
      mey_in = ey_in[DIFF_W-1] ? DIFF_W'(-ey_in) : DIFF_W'(ey_in);
      side_in = '{cx: center_x, cy: center_y, r: radius, sx: start_x, sy: start_y,
                  bx: end_x, by: end_y, neg_x: ex_in[DIFF_W-1],
                  neg_y: ey_in[DIFF_W-1], sel: KSEL_START};
   end

   always_comb begin
      exx_in = ex_ff * ex_ff;
      eyy_in = ey_ff * ey_ff;
      pxe_in = px_ff * ex_ff;
      pye_in = py_ff * ey_ff;
   end

   always_comb begin
      len3_in = exx_ff + eyy_ff;
      dot_in  = DOT_W'(pxe_ff) + DOT_W'(pye_ff);
   end

   always_comb begin
      dot_pos  = !dot_ff[DOT_W-1] && (dot_ff != '0);
      side4_in = side3_ff;
      if (!dot_pos) begin
         side4_in.sel = KSEL_START;
      end else if (dot_ff[DOT_W-2:0] >= len3_ff) begin
         side4_in.sel = KSEL_END;
      end else begin
         side4_in.sel = KSEL_DIV;
      end
      // in the divide case dot < len, so the top bits of dot are zero
      plx_in = dot_ff[SPLIT_W-1:0] * mex3_ff;
      ply_in = dot_ff[SPLIT_W-1:0] * mey3_ff;
      phx_in = dot_ff[2*SPLIT_W-2:SPLIT_W] * mex3_ff;
      phy_in = dot_ff[2*SPLIT_W-2:SPLIT_W] * mey3_ff;
   end

   always_comb begin
      nx_in = PN_W'(plx_ff) + (PN_W'(phx_ff) << SPLIT_W);
      ny_in = PN_W'(ply_ff) + (PN_W'(phy_ff) << SPLIT_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
      end
      ex_ff    <= ex_in;
      ey_ff    <= ey_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      mex1_ff  <= mex_in;
      mey1_ff  <= mey_in;
      side1_ff <= side_in;

      exx_ff   <= exx_in;
      eyy_ff   <= eyy_in;
      pxe_ff   <= pxe_in;
      pye_ff   <= pye_in;
      mex2_ff  <= mex1_ff;
      mey2_ff  <= mey1_ff;
      side2_ff <= side1_ff;

      len3_ff  <= len3_in;
      dot_ff   <= dot_in;
      mex3_ff  <= mex2_ff;
      mey3_ff  <= mey2_ff;
      side3_ff <= side2_ff;

      plx_ff   <= plx_in;
      ply_ff   <= ply_in;
      phx_ff   <= phx_in;
      phy_ff   <= phy_in;
      len4_ff  <= len3_ff;
      side4_ff <= side4_in;

      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      len5_ff  <= len4_ff;
      side5_ff <= side4_ff;
   end

   assign out_valid = vld5_ff;
   assign num_x     = nx_ff;
   assign num_y     = ny_ff;
   assign len       = len5_ff;
   assign out_side  = side5_ff;

endmodule

[src/csc_proj_div.sv]
module csc_proj_div import csc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [PN_W-1:0]     num_x,
   input  logic [PN_W-1:0]     num_y,
   input  logic [LEN_W-1:0]    len,
   input  proj_side_type       in_side,
   output logic                out_valid,
   output logic [PQ_BITS-1:0]  quo_x,
   output logic [PQ_BITS-1:0]  quo_y,
   output proj_side_type       out_side
);

   // one quotient bit per stage, MSB first; both axes share the divisor
   logic                vld_ff  [PQ_BITS];
   logic [PN_W-1:0]     rx_ff   [PQ_BITS];
   logic [PN_W-1:0]     ry_ff   [PQ_BITS];
   logic [PQ_BITS-1:0]  qx_ff   [PQ_BITS];
   logic [PQ_BITS-1:0]  qy_ff   [PQ_BITS];
   logic [LEN_W-1:0]    len_ff  [PQ_BITS];
   proj_side_type       side_ff [PQ_BITS];

   for (genvar j = 0; j < PQ_BITS; j++) begin : g_step
      localparam int Sh = PQ_BITS - 1 - j;
      logic                vld_src;
      logic [PN_W-1:0]     rx_src, ry_src, rx_in, ry_in;
      logic [PQ_BITS-1:0]  qx_src, qy_src, qx_in, qy_in;
      logic [LEN_W-1:0]    len_src;
      proj_side_type       side_src;
      logic [PC_W-1:0]     dvs;
      logic                ge_x, ge_y;

      if (j == 0) begin : g_head
         assign vld_src  = in_valid;
         assign rx_src   = num_x;
         assign ry_src   = num_y;
         assign qx_src   = '0;
         assign qy_src   = '0;
         assign len_src  = len;
         assign side_src = in_side;
      end else begin : g_body
         assign vld_src  = vld_ff[j-1];
         assign rx_src   = rx_ff[j-1];
         assign ry_src   = ry_ff[j-1];
         assign qx_src   = qx_ff[j-1];
         assign qy_src   = qy_ff[j-1];
         assign len_src  = len_ff[j-1];
         assign side_src = side_ff[j-1];
      end

      always_comb begin
         dvs   = PC_W'(len_src) << Sh;
         ge_x  = PC_W'(rx_src) >= dvs;
         ge_y  = PC_W'(ry_src) >= dvs;
         rx_in = ge_x ? rx_src - dvs[PN_W-1:0] : rx_src;
         ry_in = ge_y ? ry_src - dvs[PN_W-1:0] : ry_src;
         qx_in = qx_src;
         qy_in = qy_src;
         qx_in[Sh] = ge_x;
         qy_in[Sh] = ge_y;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= vld_src;
         end
         rx_ff[j]   <= rx_in;
         ry_ff[j]   <= ry_in;
         qx_ff[j]   <= qx_in;
         qy_ff[j]   <= qy_in;
         len_ff[j]  <= len_src;
         side_ff[j] <= side_src;
      end
   end

   assign out_valid = vld_ff[PQ_BITS-1];
   assign quo_x     = qx_ff[PQ_BITS-1];
   assign quo_y     = qy_ff[PQ_BITS-1];
   assign out_side  = side_ff[PQ_BITS-1];

endmodule

[src/csc_sqrt.sv]
module csc_sqrt import csc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [SQ_W-1:0]    value,
   input  sqrt_side_type      in_side,
   output logic               out_valid,
   output logic [ROOT_W-1:0]  root,
   output logic [SQ_W-1:0]    rem,
   output sqrt_side_type      out_side
);

   // digit-by-digit root, one result bit per stage; rem ends as value - root^2
   logic              vld_ff  [SQ_STEPS];
   logic [SQ_W-1:0]   x_ff    [SQ_STEPS];
   logic [SQ_W-1:0]   res_ff  [SQ_STEPS];
   sqrt_side_type     side_ff [SQ_STEPS];

   for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
      localparam int Sh = 2 * (SQ_STEPS - 1 - j);
      logic              vld_src, ge;
      logic [SQ_W-1:0]   x_src, res_src, bitv, trial, x_in, res_in;
      sqrt_side_type     side_src;

      if (j == 0) begin : g_head
         assign vld_src  = in_valid;
         assign x_src    = value;
         assign res_src  = '0;
         assign side_src = in_side;
      end else begin : g_body
         assign vld_src  = vld_ff[j-1];
         assign x_src    = x_ff[j-1];
         assign res_src  = res_ff[j-1];
         assign side_src = side_ff[j-1];
      end

      always_comb begin
         bitv   = SQ_W'(1) << Sh;
         trial  = res_src + bitv;
         ge     = x_src >= trial;
         x_in   = ge ? x_src - trial : x_src;
         res_in = ge ? (res_src >> 1) + bitv : res_src >> 1;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= vld_src;
         end
         x_ff[j]    <= x_in;
         res_ff[j]  <= res_in;
         side_ff[j] <= side_src;
      end
   end

   assign out_valid = vld_ff[SQ_STEPS-1];
   assign root      = res_ff[SQ_STEPS-1][ROOT_W-1:0];
   assign rem       = x_ff[SQ_STEPS-1];
   assign out_side  = side_ff[SQ_STEPS-1];

endmodule

[src/csc_norm_div.sv]
module csc_norm_div import csc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [NN_W-1:0]     num_x,
   input  logic [NN_W-1:0]     num_y,
   input  logic [ND_W-1:0]     divisor,
   input  norm_side_type       in_side,
   output logic                out_valid,
   output logic [NQ_BITS-1:0]  quo_x,
   output logic [NQ_BITS-1:0]  quo_y,
   output norm_side_type       out_side
);

   // |component| never exceeds the rounded distance, so NQ_BITS bits hold the quotient
   logic                vld_ff  [NQ_BITS];
   logic [NN_W-1:0]     rx_ff   [NQ_BITS];
   logic [NN_W-1:0]     ry_ff   [NQ_BITS];
   logic [NQ_BITS-1:0]  qx_ff   [NQ_BITS];
   logic [NQ_BITS-1:0]  qy_ff   [NQ_BITS];
   logic [ND_W-1:0]     d_ff    [NQ_BITS];
   norm_side_type       side_ff [NQ_BITS];

   for (genvar j = 0; j < NQ_BITS; j++) begin : g_step
      localparam int Sh = NQ_BITS - 1 - j;
      logic                vld_src, ge_x, ge_y;
      logic [NN_W-1:0]     rx_src, ry_src, rx_in, ry_in;
      logic [NQ_BITS-1:0]  qx_src, qy_src, qx_in, qy_in;
      logic [ND_W-1:0]     d_src;
      norm_side_type       side_src;
      logic [NC_W-1:0]     dvs;

      if (j == 0) begin : g_head
         assign vld_src  = in_valid;
         assign rx_src   = num_x;
         assign ry_src   = num_y;
         assign qx_src   = '0;
         assign qy_src   = '0;
         assign d_src    = divisor;
         assign side_src = in_side;
      end else begin : g_body
         assign vld_src  = vld_ff[j-1];
         assign rx_src   = rx_ff[j-1];
         assign ry_src   = ry_ff[j-1];
         assign qx_src   = qx_ff[j-1];
         assign qy_src   = qy_ff[j-1];
         assign d_src    = d_ff[j-1];
         assign side_src = side_ff[j-1];
      end

      always_comb begin
         dvs   = NC_W'(d_src) << Sh;
         ge_x  = NC_W'(rx_src) >= dvs;
         ge_y  = NC_W'(ry_src) >= dvs;
         rx_in = ge_x ? rx_src - dvs[NN_W-1:0] : rx_src;
         ry_in = ge_y ? ry_src - dvs[NN_W-1:0] : ry_src;
         qx_in = qx_src;
         qy_in = qy_src;
         qx_in[Sh] = ge_x;
         qy_in[Sh] = ge_y;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= vld_src;
         end
         rx_ff[j]   <= rx_in;
         ry_ff[j]   <= ry_in;
         qx_ff[j]   <= qx_in;
         qy_ff[j]   <= qy_in;
         d_ff[j]    <= d_src;
         side_ff[j] <= side_src;
      end
   end

   assign out_valid = vld_ff[NQ_BITS-1];
   assign quo_x     = qx_ff[NQ_BITS-1];
   assign quo_y     = qy_ff[NQ_BITS-1];
   assign out_side  = side_ff[NQ_BITS-1];

endmodule

[src/circle_segment_contact.sv]
// Circle versus line segment contact unit.
// Input word: circle center, radius and segment endpoints in Q16.16, presented on the
//   req_ ports with start high. A word is taken at each rising edge with start high
//   and busy low; busy is high only while reset is held, so one word per cycle.
// Result word: one per input word, in input order, on the rsp_ ports for exactly one
//   cycle while rsp_strobe is high. The receiver cannot hold results off, and none is
//   needed: nothing in the pipe ever waits.
// Pipeline: a word passes the front end, projection divide, contact/distance, square
//   root, rounding, normal divide and output register, in that order. Throughput one
//   word per cycle.
// Reset (synchronous, active high) drops every word in flight; only valid and result flag bits reset.
// Result: hit when the circle touches and the center is off the segment; on_segment
//   when the center lies on it (penetration = radius, normal zero). No touch gives an
//   all-zero word with rsp_strobe high.
module circle_segment_contact import csc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [COORD_W-1:0]         req_center_x,
   input  logic [COORD_W-1:0]         req_center_y,
   input  logic [RAD_W-1:0]           req_circle_radius,
   input  logic [COORD_W-1:0]         req_start_x,
   input  logic [COORD_W-1:0]         req_start_y,
   input  logic [COORD_W-1:0]         req_end_x,
   input  logic [COORD_W-1:0]         req_end_y,
   output logic                       rsp_strobe,
   output logic                       rsp_hit,
   output logic                       rsp_on_segment,
   output logic [COORD_W-1:0]         rsp_contact_x,
   output logic [COORD_W-1:0]         rsp_contact_y,
   output logic [RAD_W-1:0]           rsp_penetration,
   output logic [NORM_W-1:0]          rsp_normal_x,
   output logic [NORM_W-1:0]          rsp_normal_y
);

   logic accept;

   // front end -> projection divider
   logic                 f_vld;
   logic [PN_W-1:0]      f_nx, f_ny;
   logic [LEN_W-1:0]     f_len;
   proj_side_type        f_side;

   // projection divider -> contact point
   logic                 p_vld;
   logic [PQ_BITS-1:0]   p_qx, p_qy;
   proj_side_type        p_side;

   // contact point stage
   logic [COORD_W-1:0]       kx_in, ky_in, kx_ff, ky_ff;
   logic signed [DIFF_W-1:0] dx_in, dy_in, dx_ff, dy_ff;
   logic [RAD_W-1:0]         kr_ff;
   logic                     k_vld_ff;

   // squares stage
   logic signed [PROD_W-1:0] dxx_in, dyy_in, dxx_ff, dyy_ff;
   logic [2*RAD_W-1:0]       rsq_in, rsq_ff;
   logic [DIFF_W-1:0]        adx, ady;
   logic [RAD_W-1:0]         mx_ff, my_ff;
   logic                     sgx_ff, sgy_ff;
   logic [COORD_W-1:0]       mkx_ff, mky_ff;
   logic [RAD_W-1:0]         mr_ff;
   logic                     m_vld_ff;

   // touch test stage
   logic [LEN_W-1:0]         dsq;
   logic [SQ_W-1:0]          t_v_ff;
   sqrt_side_type            t_side_in, t_side_ff;
   logic                     t_vld_ff;

   // square root -> rounding
   logic                     s_vld;
   logic [ROOT_W-1:0]        s_root;
   logic [SQ_W-1:0]          s_rem;
   sqrt_side_type            s_side;

   // rounding stage
   logic [ROOT_W-1:0]        d_in, d_ff;
   logic [NN_W-1:0]          nx_ff, ny_ff;
   norm_side_type            r_side_in, r_side_ff;
   logic                     r_vld_ff;

   // normal divider -> output
   logic                     n_vld;
   logic [NQ_BITS-1:0]       n_qx, n_qy;
   norm_side_type            n_side;

   // output register
   logic [NQ_BITS-1:0]       satx, saty;
   logic                     hit_in, on_in;
   logic                     strobe_ff, hit_ff, on_ff;
   logic [COORD_W-1:0]       cx_in, cy_in, cx_ff, cy_ff;
   logic [RAD_W-1:0]         pen_in, pen_ff;
   logic [NORM_W-1:0]        nrx_in, nry_in, nrx_ff, nry_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   csc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .center_x  (req_center_x),
      .center_y  (req_center_y),
      .radius    (req_circle_radius),
      .start_x   (req_start_x),
      .start_y   (req_start_y),
      .end_x     (req_end_x),
      .end_y     (req_end_y),
      .out_valid (f_vld),
      .num_x     (f_nx),
      .num_y     (f_ny),
      .len       (f_len),
      .out_side  (f_side)
   );

   csc_proj_div u_proj_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_vld),
      .num_x     (f_nx),
      .num_y     (f_ny),
      .len       (f_len),
      .in_side   (f_side),
      .out_valid (p_vld),
      .quo_x     (p_qx),
      .quo_y     (p_qy),
      .out_side  (p_side)
   );

   // closest point: start, end, or start plus the signed truncated offset
   always_comb begin
      case (p_side.sel)
         KSEL_END: begin
            kx_in = p_side.bx;
            ky_in = p_side.by;
         end
         KSEL_DIV: begin
            kx_in = p_side.neg_x ? p_side.sx - p_qx[COORD_W-1:0]
                                 : p_side.sx + p_qx[COORD_W-1:0];
            ky_in = p_side.neg_y ? p_side.sy - p_qy[COORD_W-1:0]
                                 : p_side.sy + p_qy[COORD_W-1:0];
         end
         default: begin
            kx_in = p_side.sx;
            ky_in = p_side.sy;
         end
      endcase
      dx_in = $signed({p_side.cx[COORD_W-1], p_side.cx}) - $signed({kx_in[COORD_W-1], kx_in});
      dy_in = $signed({p_side.cy[COORD_W-1], p_side.cy}) - $signed({ky_in[COORD_W-1], ky_in});
   end

   always_comb begin
      dxx_in = dx_ff * dx_ff;
      dyy_in = dy_ff * dy_ff;
      rsq_in = kr_ff * kr_ff;
      adx    = dx_ff[DIFF_W-1] ? DIFF_W'(-dx_ff) : DIFF_W'(dx_ff);
      ady    = dy_ff[DIFF_W-1] ? DIFF_W'(-dy_ff) : DIFF_W'(dy_ff);
   end

   // touch when dsq <= r^2; then dsq < 2^62 and the root fits the unit
   always_comb begin
      dsq = dxx_ff + dyy_ff;
      t_side_in = '{touch: dsq <= LEN_W'(rsq_ff), on_seg: dsq == '0,
                    kx: mkx_ff, ky: mky_ff, r: mr_ff, mx: mx_ff, my: my_ff,
                    sgx: sgx_ff, sgy: sgy_ff};
   end

   csc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t_vld_ff),
      .value     (t_v_ff),
      .in_side   (t_side_ff),
      .out_valid (s_vld),
      .root      (s_root),
      .rem       (s_rem),
      .out_side  (s_side)
   );

   // round to nearest: bump when value - root^2 exceeds root
   always_comb begin
      d_in = s_root + ROOT_W'(s_rem > SQ_W'(s_root));
      r_side_in = '{touch: s_side.touch, on_seg: s_side.on_seg,
                    kx: s_side.kx, ky: s_side.ky,
                    pen: s_side.on_seg ? s_side.r : s_side.r - d_in[RAD_W-1:0],
                    sgx: s_side.sgx, sgy: s_side.sgy};
   end

   csc_norm_div u_norm_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (r_vld_ff),
      .num_x     (nx_ff),
      .num_y     (ny_ff),
      .divisor   (d_ff),
      .in_side   (r_side_ff),
      .out_valid (n_vld),
      .quo_x     (n_qx),
      .quo_y     (n_qy),
      .out_side  (n_side)
   );

   // result word; every field is zero when there is no touch
   always_comb begin
      satx   = (n_qx > NORM_ONE) ? NORM_ONE : n_qx;
      saty   = (n_qy > NORM_ONE) ? NORM_ONE : n_qy;
      hit_in = n_vld && n_side.touch && !n_side.on_seg;
      on_in  = n_vld && n_side.touch && n_side.on_seg;
      cx_in  = n_side.touch ? n_side.kx : '0;
      cy_in  = n_side.touch ? n_side.ky : '0;
      pen_in = n_side.touch ? n_side.pen : '0;
      nrx_in = '0;
      nry_in = '0;
      if (hit_in) begin
         nrx_in = n_side.sgx ? -NORM_W'(satx) : NORM_W'(satx);
         nry_in = n_side.sgy ? -NORM_W'(saty) : NORM_W'(saty);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_vld_ff  <= 1'b0;
         m_vld_ff  <= 1'b0;
         t_vld_ff  <= 1'b0;
         r_vld_ff  <= 1'b0;
         strobe_ff <= 1'b0;
         hit_ff    <= 1'b0;
         on_ff     <= 1'b0;
      end else begin
         k_vld_ff  <= p_vld;
         m_vld_ff  <= k_vld_ff;
         t_vld_ff  <= m_vld_ff;
         r_vld_ff  <= s_vld;
         strobe_ff <= n_vld;
         hit_ff    <= hit_in;
         on_ff     <= on_in;
      end
      kx_ff     <= kx_in;
      ky_ff     <= ky_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      kr_ff     <= p_side.r;

      dxx_ff    <= dxx_in;
      dyy_ff    <= dyy_in;
      rsq_ff    <= rsq_in;
      mx_ff     <= adx[RAD_W-1:0];
      my_ff     <= ady[RAD_W-1:0];
      sgx_ff    <= dx_ff[DIFF_W-1];
      sgy_ff    <= dy_ff[DIFF_W-1];
      mkx_ff    <= kx_ff;
      mky_ff    <= ky_ff;
      mr_ff     <= kr_ff;

      t_v_ff    <= SQ_W'(dsq[2*RAD_W-1:0]);
      t_side_ff <= t_side_in;

      d_ff      <= d_in;
      nx_ff     <= {s_side.mx, FRAC_BITS'(0)};
      ny_ff     <= {s_side.my, FRAC_BITS'(0)};
      r_side_ff <= r_side_in;

      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      pen_ff    <= pen_in;
      nrx_ff    <= nrx_in;
      nry_ff    <= nry_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_on_segment  = on_ff;
   assign rsp_contact_x   = cx_ff;
   assign rsp_contact_y   = cy_ff;
   assign rsp_penetration = pen_ff;
   assign rsp_normal_x    = nrx_ff;
   assign rsp_normal_y    = nry_ff;

endmodule

[src/csc_checker.sv]
`include "circle_segment_contact_macros.svh"

module csc_checker import csc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic               rsp_hit,
   input logic               rsp_on_segment,
   input logic [NORM_W-1:0]  rsp_normal_x,
   input logic [NORM_W-1:0]  rsp_normal_y
);

   logic taken, norm_zero;

   assign taken     = start && !busy;
   assign norm_zero = (rsp_normal_x == '0) && (rsp_normal_y == '0);

   // every result word traces back to a word taken a fixed latency earlier
   `CSC_ASSERT_SAME(a_rsp_has_req, rsp_strobe, $past(taken, LATENCY), "result without request")

   `CSC_ASSERT_SAME(a_hit_excl, rsp_hit, rsp_strobe && !rsp_on_segment, "stray hit")

   `CSC_ASSERT_SAME(a_onseg_norm, rsp_on_segment, rsp_strobe && norm_zero, "on_segment with normal")

   `CSC_ASSERT_SAME(a_hit_norm, rsp_hit, !norm_zero, "hit with a zero normal")

   // taken words are flushed by reset, so none comes out right after it
   `CSC_ASSERT_NEXT(a_reset_flush, $fell(reset), !rsp_strobe, "result word right after reset")

endmodule

bind circle_segment_contact csc_checker u_csc_checker (.*);
